@@ rtl/core/wop_pkg.sv @@
// ----------------------------------------------------------------------------
// Picker package
// Widths, codes, sequencer states and the table write bundle shared by the
// picker core and its entry table.
// ----------------------------------------------------------------------------
package wop_pkg;

    localparam int MAX_ENTRIES = 16;

    localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int CMD_W    = 2;
    localparam int MODE_W   = 2;
    localparam int TYPE_W   = 8;
    localparam int WEIGHT_W = 16;
    localparam int RND_W    = 16;
    localparam int TOTAL_W  = 20;

    localparam int ACC_W  = WEIGHT_W + CNT_W;
    localparam int SAT_W  = (ACC_W > TOTAL_W) ? ACC_W : TOTAL_W;
    localparam int THR_W  = RND_W + TOTAL_W;
    localparam int SHL_W  = ACC_W + RND_W;
    localparam int CMPX_W = (SHL_W > THR_W) ? SHL_W : THR_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RANDOM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ORDERED = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_START  = 2'd2,
        CMD_NEXT   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_WALK,
        ST_ORD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [TYPE_W-1:0]   etype;
        logic [WEIGHT_W-1:0] weight;
    } tbl_wr_t;

endpackage

@@ rtl/core/wop_table.sv @@
// ----------------------------------------------------------------------------
// Picker entry table
// Type and weight storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wop_table (
    input  logic                          clk,
    input  wop_pkg::tbl_wr_t              wr,
    input  logic [wop_pkg::IDX_W-1:0]     rd_addr,
    output logic [wop_pkg::TYPE_W-1:0]    rd_type,
    output logic [wop_pkg::WEIGHT_W-1:0]  rd_weight
);
    import wop_pkg::*;

    logic [TYPE_W-1:0]   type_mem   [MAX_ENTRIES];
    logic [WEIGHT_W-1:0] weight_mem [MAX_ENTRIES];
    logic [TYPE_W-1:0]   rd_type_reg;
    logic [WEIGHT_W-1:0] rd_weight_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            type_mem[wr.addr]   <= wr.etype;
            weight_mem[wr.addr] <= wr.weight;
        end
        rd_type_reg   <= type_mem[rd_addr];
        rd_weight_reg <= weight_mem[rd_addr];
    end

    assign rd_type   = rd_type_reg;
    assign rd_weight = rd_weight_reg;

endmodule

@@ rtl/core/weighted_or_ordered_picker.sv @@
// ----------------------------------------------------------------------------
// Weighted or ordered picker
// Keeps a table of up to 16 type/weight entries and returns one result per
// pick command: an entry chosen by weight against a random fraction or in
// turn, or the default. Clear and append return nothing. An ordered pick
// reads the entry at the round-robin position before the finish state, and a
// default pick goes straight to it. A weighted pick steps one table entry
// per cycle through a single shared adder and comparator fed by the table's
// read port: pick next forms the threshold and walks to the first hit; a
// weighted start first walks the table once more to rebuild the total. The
// input is not ready while a pick is in progress; a finished result sits in
// an output register and the next command is taken while it waits.
// ----------------------------------------------------------------------------
module weighted_or_ordered_picker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wop_pkg::MODE_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wop_pkg::CMD_W-1:0]     command,
    input  logic [wop_pkg::TYPE_W-1:0]    entry_type,
    input  logic [wop_pkg::WEIGHT_W-1:0]  entry_weight,
    input  logic [wop_pkg::RND_W-1:0]     random_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wop_pkg::TYPE_W-1:0]    picked_type,
    output logic                          picked_default
);
    import wop_pkg::*;

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   pick_mode_reg;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [TOTAL_W-1:0]  weight_total_reg, weight_total_next;
    logic [IDX_W-1:0]    order_pos_reg, order_pos_next;
    logic [CNT_W-1:0]    walk_cnt_reg, walk_cnt_next;
    logic                pend_reg, pend_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [THR_W-1:0]    threshold_reg, threshold_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic [TYPE_W-1:0]   res_type_reg, res_type_next;
    logic                res_def_reg, res_def_next;
    logic                out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0]   picked_type_reg, picked_type_next;
    logic                picked_default_reg, picked_default_next;

    tbl_wr_t             tbl_wr;
    logic [IDX_W-1:0]    rd_addr;
    logic [TYPE_W-1:0]   rd_type;
    logic [WEIGHT_W-1:0] rd_weight;

    cmd_t                cmd;
    logic                accept;
    logic                is_pick;
    logic                table_empty;
    logic                walk_issue;
    logic                walk_done;
    logic [ACC_W-1:0]    sum_val;
    logic [SAT_W-1:0]    acc_ext;
    logic [CMPX_W-1:0]   shifted;
    logic                hit;
    logic [IDX_W-1:0]    pos_eff;
    logic [IDX_W-1:0]    pos_wrapped;
    logic                out_free;

    wop_table u_table (
        .clk       (clk),
        .wr        (tbl_wr),
        .rd_addr   (rd_addr),
        .rd_type   (rd_type),
        .rd_weight (rd_weight)
    );

    assign cmd         = cmd_t'(command);
    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign is_pick     = (cmd == CMD_START) || (cmd == CMD_NEXT);
    assign table_empty = (entry_count_reg == '0);
    assign walk_issue  = (walk_cnt_reg < entry_count_reg);
    assign walk_done   = !walk_issue && !pend_reg;
    assign sum_val     = acc_reg + ACC_W'(rd_weight);
    assign acc_ext     = SAT_W'(acc_reg);
    assign shifted     = CMPX_W'({sum_val, {RND_W{1'b0}}});
    assign hit         = pend_reg && (shifted > CMPX_W'(threshold_reg));
    assign pos_eff     = (cmd == CMD_START) ? '0 : order_pos_reg;
    assign pos_wrapped = (CNT_W'(pos_eff) >= entry_count_reg) ? '0 : pos_eff;
    assign out_free    = !out_valid_reg || out_ready;
    assign rd_addr     = (state_reg == ST_IDLE) ? pos_wrapped : walk_cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_pick)
                begin
                    unique case (pick_mode_reg)
                        MODE_RANDOM:  state_next = (cmd == CMD_START) ? ST_SUM : ST_MUL;
                        MODE_ORDERED: state_next = table_empty ? ST_FINISH : ST_ORD;
                        default:      state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SUM:
            begin
                if (walk_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = (table_empty || weight_total_reg == '0) ? ST_FINISH : ST_WALK;
            end
            ST_WALK:
            begin
                if (hit || walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ORD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        entry_count_next  = entry_count_reg;
        weight_total_next = weight_total_reg;
        order_pos_next    = order_pos_reg;
        walk_cnt_next     = walk_cnt_reg;
        pend_next         = 1'b0;
        acc_next          = acc_reg;
        threshold_next    = threshold_reg;
        rnd_next          = rnd_reg;
        res_type_next     = res_type_reg;
        res_def_next      = res_def_reg;
        tbl_wr            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rnd_next      = random_value;
                    walk_cnt_next = '0;
                    acc_next      = '0;
                    res_type_next = '0;
                    res_def_next  = 1'b1;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            entry_count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (entry_count_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                tbl_wr.en        = 1'b1;
                                tbl_wr.addr      = entry_count_reg[IDX_W-1:0];
                                tbl_wr.etype     = entry_type;
                                tbl_wr.weight    = entry_weight;
                                entry_count_next = entry_count_reg + CNT_W'(1);
                            end
                        end
                        CMD_START, CMD_NEXT:
                        begin
                            if (pick_mode_reg == MODE_ORDERED)
                            begin
                                order_pos_next = table_empty ? pos_wrapped
                                                             : pos_wrapped + IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            entry_count_next = entry_count_reg;
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                walk_cnt_next = walk_issue ? walk_cnt_reg + CNT_W'(1) : walk_cnt_reg;
                pend_next     = walk_issue;
                if (pend_reg)
                begin
                    acc_next = sum_val;
                end
                if (walk_done)
                begin
                    weight_total_next = (acc_ext > SAT_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                      : TOTAL_W'(acc_ext);
                end
            end
            ST_MUL:
            begin
                threshold_next = THR_W'(rnd_reg) * THR_W'(weight_total_reg);
                acc_next       = '0;
                walk_cnt_next  = '0;
            end
            ST_WALK:
            begin
                walk_cnt_next = walk_issue ? walk_cnt_reg + CNT_W'(1) : walk_cnt_reg;
                pend_next     = walk_issue && !hit;
                if (hit)
                begin
                    res_type_next = rd_type;
                    res_def_next  = 1'b0;
                end
                else if (pend_reg)
                begin
                    acc_next = sum_val;
                end
            end
            ST_ORD:
            begin
                res_type_next = rd_type;
                res_def_next  = 1'b0;
            end
            ST_FINISH:
            begin
                res_def_next = res_def_reg;
            end
            default:
            begin
                res_def_next = res_def_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next      = out_valid_reg && !out_ready;
        picked_type_next    = picked_type_reg;
        picked_default_next = picked_default_reg;
        if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_next      = 1'b1;
            picked_type_next    = res_type_reg;
            picked_default_next = res_def_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pick_mode_reg    <= MODE_DEFAULT;
            entry_count_reg  <= '0;
            weight_total_reg <= '0;
            order_pos_reg    <= '0;
            walk_cnt_reg     <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            weight_total_reg <= weight_total_next;
            order_pos_reg    <= order_pos_next;
            walk_cnt_reg     <= walk_cnt_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                pick_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg            <= acc_next;
        threshold_reg      <= threshold_next;
        rnd_reg            <= rnd_next;
        res_type_reg       <= res_type_next;
        res_def_reg        <= res_def_next;
        picked_type_reg    <= picked_type_next;
        picked_default_reg <= picked_default_next;
    end

    assign out_valid      = out_valid_reg;
    assign picked_type    = picked_type_reg;
    assign picked_default = picked_default_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> (weight_total_reg != '0) && (entry_count_reg != '0))
        else $error("weighted walk with empty table or zero total");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

    a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && !out_valid_reg |=>
            (state_reg == ST_IDLE) && out_valid_reg)
        else $error("finished result not transferred to output");
`endif

endmodule

@@ tb/weighted_or_ordered_picker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted or ordered picker testbench
// Drives clear, append, start and pick commands through the valid/ready input
// and checks every pick against a cycle-free model of the entry table, the
// weight total and the round-robin position. Directed runs cover each pick
// mode, its corner cases and a long output stall, then random table builds
// and picks run across the mode settings with random idling and drain pauses.
// ----------------------------------------------------------------------------
module weighted_or_ordered_picker_tb;

    import wop_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned MAX_PRINTED = 100;

    typedef struct packed {
        logic [TYPE_W-1:0] ptype;
        logic              dflt;
    } pick_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [MODE_W-1:0]   cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [CMD_W-1:0]    command;
    logic [TYPE_W-1:0]   entry_type;
    logic [WEIGHT_W-1:0] entry_weight;
    logic [RND_W-1:0]    random_value;
    logic                out_valid;
    logic                out_ready;
    logic [TYPE_W-1:0]   picked_type;
    logic                picked_default;

    logic [TYPE_W-1:0]   tbl_type [MAX_ENTRIES];
    logic [WEIGHT_W-1:0] tbl_weight [MAX_ENTRIES];
    int unsigned         tbl_count;
    logic [TOTAL_W-1:0]  weight_total;
    int unsigned         order_pos;
    logic [MODE_W-1:0]   pick_mode;

    pick_t       expected_picks[$];
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned stall_request;
    int unsigned idle_cycles;
    bit          calm;

    weighted_or_ordered_picker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .entry_type     (entry_type),
        .entry_weight   (entry_weight),
        .random_value   (random_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .picked_type    (picked_type),
        .picked_default (picked_default)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pick_t default_pick();
        pick_t r;
        r.ptype = '0;
        r.dflt  = 1'b1;
        return r;
    endfunction

    function automatic pick_t weighted_pick(input logic [RND_W-1:0] rnd);
        logic [39:0] threshold;
        logic [39:0] running;
        pick_t       r;
        r = default_pick();
        if (tbl_count == 0 || weight_total == 0)
            return r;
        threshold = 40'(rnd) * 40'(weight_total);
        running = '0;
        for (int i = 0; i < tbl_count; i++)
        begin
            running = running + 40'(tbl_weight[i]);
            if ((running << 16) > threshold)
            begin
                r.ptype = tbl_type[i];
                r.dflt  = 1'b0;
                return r;
            end
        end
        return r;
    endfunction

    function automatic pick_t ordered_pick();
        pick_t r;
        r = default_pick();
        if (order_pos >= tbl_count)
            order_pos = 0;
        if (tbl_count == 0)
            return r;
        r.ptype = tbl_type[order_pos];
        r.dflt  = 1'b0;
        order_pos++;
        return r;
    endfunction

    function automatic pick_t pick_by_mode(input logic [RND_W-1:0] rnd);
        if (pick_mode == MODE_RANDOM)
            return weighted_pick(rnd);
        if (pick_mode == MODE_ORDERED)
            return ordered_pick();
        return default_pick();
    endfunction

    task automatic predict_command(input cmd_t cmd, input logic [TYPE_W-1:0] etype,
                                   input logic [WEIGHT_W-1:0] weight,
                                   input logic [RND_W-1:0] rnd);
        logic [39:0] sum;
        case (cmd)
            CMD_CLEAR:
                tbl_count = 0;
            CMD_APPEND:
                if (tbl_count < MAX_ENTRIES)
                begin
                    tbl_type[tbl_count]   = etype;
                    tbl_weight[tbl_count] = weight;
                    tbl_count++;
                end
            CMD_START:
            begin
                if (pick_mode == MODE_RANDOM)
                begin
                    sum = '0;
                    for (int i = 0; i < tbl_count; i++)
                        sum = sum + 40'(tbl_weight[i]);
                    weight_total = (sum > 40'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                end
                else if (pick_mode == MODE_ORDERED)
                begin
                    order_pos = 0;
                end
                expected_picks.push_back(pick_by_mode(rnd));
            end
            default:
                expected_picks.push_back(pick_by_mode(rnd));
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_command(input cmd_t cmd, input logic [TYPE_W-1:0] etype,
                                input logic [WEIGHT_W-1:0] weight,
                                input logic [RND_W-1:0] rnd);
        while (!calm && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        entry_type   <= etype;
        entry_weight <= weight;
        random_value <= rnd;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        predict_command(cmd, etype, weight, rnd);
    endtask

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return WEIGHT_W'($urandom_range(255));
            default: return WEIGHT_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [RND_W-1:0] random_fraction();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return RND_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_random(input cmd_t cmd);
        send_command(cmd, TYPE_W'($urandom_range(255)), random_weight(), random_fraction());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_picks.size() != 0);
    endtask

    task automatic write_pick_mode(input logic [MODE_W-1:0] mode);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pick_mode = mode;
    endtask

    task automatic test_default_mode();
        send_command(CMD_NEXT, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_START, 8'hFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_ordered_mode();
        write_pick_mode(MODE_ORDERED);
        send_command(CMD_CLEAR, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_APPEND, 8'h00, 16'h0001, 16'h0000);
        send_command(CMD_APPEND, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_command(CMD_APPEND, 8'h5A, 16'h1234, 16'h0000);
        send_command(CMD_START, 8'h00, 16'h0000, 16'h0000);
        repeat (3) send_command(CMD_NEXT, 8'h00, 16'h0000, 16'h0000);
        // position now past the end of a shorter table: wrap
        send_command(CMD_CLEAR, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_APPEND, 8'h3C, 16'h0010, 16'h0000);
        send_command(CMD_NEXT, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_weighted_mode();
        write_pick_mode(MODE_RANDOM);
        send_command(CMD_CLEAR, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_APPEND, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_START, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_APPEND, 8'hA5, 16'hFFFF, 16'h0000);
        send_command(CMD_NEXT, 8'h00, 16'h0000, 16'hFFFF);
        send_command(CMD_START, 8'h00, 16'h0000, 16'hFFFF);
        send_command(CMD_START, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_NEXT, 8'h00, 16'h0000, 16'h8000);
        // keep the old total over a smaller table
        send_command(CMD_CLEAR, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_APPEND, 8'hFF, 16'h0001, 16'h0000);
        send_command(CMD_NEXT, 8'h00, 16'h0000, 16'hFFFF);
        send_command(CMD_NEXT, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_unused_mode();
        write_pick_mode(MODE_UNUSED);
        send_command(CMD_NEXT, 8'h00, 16'h0000, 16'h0000);
        send_command(CMD_START, 8'h00, 16'h0000, 16'hFFFF);
    endtask

    task automatic test_backpressure();
        write_pick_mode(MODE_ORDERED);
        send_random(CMD_CLEAR);
        repeat (4) send_random(CMD_APPEND);
        send_random(CMD_START);
        stall_request = HOLD_OFF_CYCLES;
        repeat (12) send_random(CMD_NEXT);
        drain_results();
        write_pick_mode(MODE_RANDOM);
        repeat (16) send_random(CMD_APPEND);
        send_random(CMD_START);
        stall_request = HOLD_OFF_CYCLES;
        repeat (8) send_random(CMD_NEXT);
        drain_results();
    endtask

    task automatic run_random_phase(input int unsigned count);
        int unsigned stop_at;
        int unsigned appends;
        int unsigned picks;
        int unsigned noise;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(4) != 0)
                    send_random(CMD_CLEAR);
                appends = ($urandom_range(7) == 0) ? $urandom_range(14, 18)
                                                   : $urandom_range(0, 5);
                repeat (appends) send_random(CMD_APPEND);
                send_random(CMD_START);
                picks = $urandom_range(1, 6);
                repeat (picks) send_random(CMD_NEXT);
            end
            else
            begin
                noise = $urandom_range(1, 4);
                repeat (noise) send_random(cmd_t'($urandom_range(3)));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [MODE_W-1:0] modes [8];
        modes = '{MODE_RANDOM, MODE_ORDERED, MODE_DEFAULT, MODE_RANDOM,
                  MODE_UNUSED, MODE_ORDERED, MODE_RANDOM, MODE_ORDERED};
        for (int p = 0; p < 8; p++)
        begin
            write_pick_mode(modes[p]);
            calm = (p == 3);
            run_random_phase(125);
            calm = 1'b0;
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            int unsigned hold_left;
            @(posedge clk);
            if (stall_request != 0)
            begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 19);
            end
        end
    end

    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_picks.size() == 0)
            begin
                report_mismatch("unexpected result", picked_type, 0);
            end
            else
            begin
                want = expected_picks.pop_front();
                if (picked_type !== want.ptype)
                    report_mismatch("picked_type", picked_type, want.ptype);
                if (picked_default !== want.dflt)
                    report_mismatch("picked_default", picked_default, want.dflt);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        items_sent    = 0;
        stall_request = 0;
        calm          = 1'b0;
        tbl_count     = 0;
        weight_total  = '0;
        order_pos     = 0;
        pick_mode     = MODE_DEFAULT;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= MODE_DEFAULT;
        in_valid     <= 1'b0;
        command      <= CMD_CLEAR;
        entry_type   <= '0;
        entry_weight <= '0;
        random_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_mode();
        test_ordered_mode();
        test_weighted_mode();
        test_unused_mode();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
